### hw/rtl/dhl_pkg.sv
package dhl_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int CORDIC_ITERS   = 16;
    localparam int CFG_IDX_W      = 3;

    // CORDIC start vector, 1/K with 30 fraction bits
    localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;
    localparam logic signed [15:0] Q14_ONE   = 16'sd16384;

    localparam logic signed [31:0] ATAN_PHASE [CORDIC_ITERS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
    };

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRISMATIC = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TWIST     = 3'd4;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } rot_t;

    // one word moving down the CORDIC row
    typedef struct packed {
        rot_t               theta;
        rot_t               alpha;
        logic [1:0]         theta_quad;
        logic [1:0]         alpha_quad;
        logic signed [31:0] pos_z;
    } item_t;

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [31:0] pos_x;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [31:0] pos_y;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
        logic signed [31:0] pos_z;
    } result_t;

    function automatic logic signed [15:0] clamp_q14(input logic signed [17:0] v);
        logic signed [17:0] hi;
        logic signed [17:0] lo;
        hi = 18'sd16384;
        lo = -18'sd16384;
        if (v > hi) begin
            return Q14_ONE;
        end else if (v < lo) begin
            return -Q14_ONE;
        end
        return v[15:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        hi = 34'sd2147483647;
        lo = -34'sd2147483648;
        if (v > hi) begin
            return 32'sh7FFFFFFF;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

### hw/rtl/dhl_cordic_cell.sv
module dhl_cordic_cell #(
    parameter int ITER = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  dhl_pkg::item_t in_item,
    output logic          out_valid,
    input  logic          out_ready,
    output dhl_pkg::item_t out_item
);

    logic           valid_reg;
    dhl_pkg::item_t item_reg;
    dhl_pkg::item_t item_next;

    function automatic dhl_pkg::rot_t rotate(input dhl_pkg::rot_t r);
        dhl_pkg::rot_t      o;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        dx = r.y >>> ITER;
        dy = r.x >>> ITER;
        if (!r.z[31]) begin
            o.x = r.x - dx;
            o.y = r.y + dy;
            o.z = r.z - dhl_pkg::ATAN_PHASE[ITER];
        end else begin
            o.x = r.x + dx;
            o.y = r.y - dy;
            o.z = r.z + dhl_pkg::ATAN_PHASE[ITER];
        end
        return o;
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        item_next       = in_item;
        item_next.theta = rotate(in_item.theta);
        item_next.alpha = rotate(in_item.alpha);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

### hw/rtl/dhl_post.sv
module dhl_post (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic signed [31:0] link_length,
    input  logic              in_valid,
    output logic              in_ready,
    input  dhl_pkg::item_t    in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output dhl_pkg::result_t  out_result
);

    typedef struct packed {
        logic signed [15:0] ct;
        logic signed [15:0] st;
        logic signed [15:0] ca;
        logic signed [15:0] sa;
        logic signed [31:0] pos_z;
    } trig_t;

    typedef struct packed {
        trig_t              t;
        logic signed [31:0] st_ca;
        logic signed [31:0] st_sa;
        logic signed [31:0] ct_ca;
        logic signed [31:0] ct_sa;
        logic signed [47:0] len_ct;
        logic signed [47:0] len_st;
    } prod_t;

    logic             a_valid_reg;
    logic             b_valid_reg;
    logic             c_valid_reg;
    logic             a_ready;
    logic             b_ready;
    logic             c_ready;
    trig_t            a_reg;
    trig_t            a_next;
    prod_t            b_reg;
    prod_t            b_next;
    dhl_pkg::result_t c_reg;
    dhl_pkg::result_t c_next;

    function automatic logic signed [15:0] round_q14(input logic signed [31:0] v);
        logic signed [32:0] s;
        s = {v[31], v} + 33'sd32768;
        return dhl_pkg::clamp_q14({s[32], s[32:16]});
    endfunction

    // quadrant fold: exact swaps and negations of the first-quadrant result
    function automatic logic signed [31:0] fold(input dhl_pkg::rot_t r, input logic [1:0] q);
        logic signed [15:0] cq;
        logic signed [15:0] sq;
        logic signed [15:0] c;
        logic signed [15:0] s;
        cq = round_q14(r.x);
        sq = round_q14(r.y);
        case (q)
            2'd0:    begin c = cq;  s = sq;  end
            2'd1:    begin c = -sq; s = cq;  end
            2'd2:    begin c = -cq; s = -sq; end
            default: begin c = sq;  s = -cq; end
        endcase
        return {c, s};
    endfunction

    function automatic logic signed [15:0] mul_round(input logic signed [31:0] p);
        logic signed [31:0] s;
        s = p + 32'sd8192;
        return dhl_pkg::clamp_q14(s[31:14]);
    endfunction

    function automatic logic signed [31:0] len_round(input logic signed [47:0] p);
        logic signed [47:0] s;
        s = p + 48'sd8192;
        return dhl_pkg::sat32(s[47:14]);
    endfunction

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb begin
        {a_next.ct, a_next.st} = fold(in_item.theta, in_item.theta_quad);
        {a_next.ca, a_next.sa} = fold(in_item.alpha, in_item.alpha_quad);
        a_next.pos_z           = in_item.pos_z;
    end

    always_comb begin
        b_next.t      = a_reg;
        b_next.st_ca  = a_reg.st * a_reg.ca;
        b_next.st_sa  = a_reg.st * a_reg.sa;
        b_next.ct_ca  = a_reg.ct * a_reg.ca;
        b_next.ct_sa  = a_reg.ct * a_reg.sa;
        b_next.len_ct = link_length * a_reg.ct;
        b_next.len_st = link_length * a_reg.st;
    end

    always_comb begin
        c_next.r00   = b_reg.t.ct;
        c_next.r01   = -mul_round(b_reg.st_ca);
        c_next.r02   = mul_round(b_reg.st_sa);
        c_next.pos_x = len_round(b_reg.len_ct);
        c_next.r10   = b_reg.t.st;
        c_next.r11   = mul_round(b_reg.ct_ca);
        c_next.r12   = -mul_round(b_reg.ct_sa);
        c_next.pos_y = len_round(b_reg.len_st);
        c_next.r21   = b_reg.t.sa;
        c_next.r22   = b_reg.t.ca;
        c_next.pos_z = b_reg.t.pos_z;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_reg <= a_next;
        end
        if (b_ready && a_valid_reg) begin
            b_reg <= b_next;
        end
        if (c_ready && b_valid_reg) begin
            c_reg <= c_next;
        end
    end

    assign out_valid  = c_valid_reg;
    assign out_result = c_reg;

endmodule

### hw/rtl/dh_link_transform.sv
// Standard Denavit-Hartenberg link transform, top three rows of the 4x4 matrix.
// s_axis: one word per joint set-point, s_tdata = joint_value (angle in the
//   low ANGLE_BITS bits for a revolute joint, Q16.16 offset for a prismatic one).
// m_axis: one word per input, s_tdata order kept; rotation terms in Q1.14,
//   translation in Q16.16 with saturation.
// cfg: index/data write port for joint type, fixed angle, fixed offset,
//   link length and twist; always ready. Write only while no word is in flight.
// Pipeline from s_axis accept to m_tvalid: 16 CORDIC cells, one
//   rounding/quadrant stage, one multiply stage, one output register.
// Throughput: one word per cycle; every stage holds its own valid bit, so
//   a stalled m_tready fills bubbles first and s_tready drops only once all
//   19 stages hold words. Stalled output data is held stable.
// Reset (aresetn low, synchronous): pipeline emptied, valid and cfg registers cleared.
module dh_link_transform #(
    parameter int ANGLE_BITS = dhl_pkg::ANGLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // [31:0] joint_value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] r00, [31:16] r01, [47:32] r02, [79:48] pos_x, [95:80] r10,
    // [111:96] r11, [127:112] r12, [159:128] pos_y, [175:160] r21,
    // [191:176] r22, [223:192] pos_z
    output logic [223:0]                  m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dhl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    localparam int N = dhl_pkg::CORDIC_ITERS;

    logic               prismatic_reg;
    logic [15:0]        angle_reg;
    logic signed [31:0] offset_reg;
    logic signed [31:0] length_reg;
    logic [15:0]        twist_reg;

    logic [31:0]        theta_phase;
    logic [31:0]        alpha_phase;

    dhl_pkg::item_t     head_item;
    logic               cell_valid [0:N];
    logic               cell_ready [0:N];
    dhl_pkg::item_t     cell_item  [0:N];
    dhl_pkg::result_t   result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prismatic_reg <= 1'b0;
            angle_reg     <= '0;
            offset_reg    <= '0;
            length_reg    <= '0;
            twist_reg     <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                dhl_pkg::REG_PRISMATIC: prismatic_reg <= cfg_data[0];
                dhl_pkg::REG_ANGLE:     angle_reg     <= cfg_data[15:0];
                dhl_pkg::REG_OFFSET:    offset_reg    <= cfg_data;
                dhl_pkg::REG_LENGTH:    length_reg    <= cfg_data;
                dhl_pkg::REG_TWIST:     twist_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign theta_phase = prismatic_reg ? {angle_reg, 16'h0000}
                       : {s_tdata[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
    assign alpha_phase = {twist_reg, 16'h0000};

    // first-quadrant phase feeds the CORDIC, the quadrant rides along
    always_comb begin
        head_item.theta.x    = dhl_pkg::CORDIC_X0;
        head_item.theta.y    = '0;
        head_item.theta.z    = {2'b00, theta_phase[29:0]};
        head_item.alpha.x    = dhl_pkg::CORDIC_X0;
        head_item.alpha.y    = '0;
        head_item.alpha.z    = {2'b00, alpha_phase[29:0]};
        head_item.theta_quad = theta_phase[31:30];
        head_item.alpha_quad = alpha_phase[31:30];
        head_item.pos_z      = prismatic_reg ? s_tdata : offset_reg;
    end

    assign cell_item[0]  = head_item;
    assign cell_valid[0] = s_tvalid;
    assign s_tready      = cell_ready[0];

    for (genvar i = 0; i < N; i++) begin : g_cell
        dhl_cordic_cell #(
            .ITER (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cell_valid[i]),
            .in_ready  (cell_ready[i]),
            .in_item   (cell_item[i]),
            .out_valid (cell_valid[i+1]),
            .out_ready (cell_ready[i+1]),
            .out_item  (cell_item[i+1])
        );
    end

    dhl_post u_post (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .link_length (length_reg),
        .in_valid    (cell_valid[N]),
        .in_ready    (cell_ready[N]),
        .in_item     (cell_item[N]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (result)
    );

    assign m_tdata = {result.pos_z, result.r22, result.r21, result.pos_y,
                      result.r12, result.r11, result.r10, result.pos_x,
                      result.r02, result.r01, result.r00};

endmodule
